>>> sv/sorted_insert_store_macros.svh
// Assertion macros for the checker file of the sorted store.
`ifndef SORTED_INSERT_STORE_MACROS_SVH
`define SORTED_INSERT_STORE_MACROS_SVH

// Check a property at every clock edge, outside reset.
`define SIS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check a property at every clock edge, reset included.
`define SIS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

>>> sv/sis_pkg.sv
// Types, codes and sizes shared by the sorted store modules.
package sis_pkg;

    localparam int SIS_DEPTH = 16;
    localparam int SIS_CNT_W = $clog2(SIS_DEPTH + 1);
    localparam int SIS_IDX_W = $clog2(SIS_DEPTH);

    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_READ   = 2'd1;
    localparam logic [1:0] KIND_CLEAR  = 2'd2;

    localparam logic [2:0] ST_INSERTED = 3'd0;
    localparam logic [2:0] ST_DROPPED  = 3'd1;
    localparam logic [2:0] ST_EMITTED  = 3'd2;
    localparam logic [2:0] ST_EMPTY    = 3'd3;
    localparam logic [2:0] ST_CLEARED  = 3'd4;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] value;
    } t_in_item;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] entry_value;
        logic               last;
    } t_out_item;

    typedef enum logic [2:0] {
        CELL_HOLD   = 3'b001,
        CELL_INSERT = 3'b010,
        CELL_ROTATE = 3'b100
    } t_cell_op;

    typedef struct packed {
        t_cell_op           op;
        logic signed [31:0] value;
    } t_cell_ctrl;

endpackage

>>> sv/sis_cell.sv
// One cell of the sorted chain: holds one entry and trades it with its neighbors.
module sis_cell
    import sis_pkg::*;
(
    input  logic               i_clk,
    input  t_cell_ctrl         i_ctrl,
    input  logic               i_occupied,
    input  logic               i_tail,
    input  logic               i_prev_lt,
    input  logic signed [31:0] i_prev_value,
    input  logic signed [31:0] i_next_value,
    input  logic signed [31:0] i_head_value,
    output logic signed [31:0] o_value,
    output logic               o_lt
);

    logic signed [31:0] r_value;
    logic signed [31:0] n_value;

    // Flag a stored entry that is smaller than the broadcast value
    assign o_lt    = i_occupied && (r_value < i_ctrl.value);
    assign o_value = r_value;

    always_comb begin
        n_value = r_value;
        unique case (i_ctrl.op)
            CELL_INSERT: begin
                // keep smaller entries, take the value at the boundary, shift the rest
                if (o_lt) begin
                    n_value = r_value;
                end else if (i_prev_lt) begin
                    n_value = i_ctrl.value;
                end else begin
                    n_value = i_prev_value;
                end
            end
            CELL_ROTATE: begin
                // advance toward the head; the tail wraps to the head entry
                n_value = i_tail ? i_head_value : i_next_value;
            end
            default: begin
                n_value = r_value;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule

>>> sv/sorted_insert_store.sv
// The first result of a request is registered in the output register from the accepted request.
// Insert, clear and empty read: one request per cycle while the output is taken each cycle.
// Read of n entries: n results; the cell chain rotates once per emitted entry and
// no request is taken until the final entry is registered.
// Reset (synchronous, active low) clears the fill count, the read state and the output
// valid; the cell values are not reset and need no clearing pass.
module sorted_insert_store
    import sis_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } t_state;

    t_state                 r_state,     n_state;
    logic [SIS_CNT_W-1:0]   r_count,     n_count;
    logic [SIS_IDX_W-1:0]   r_rd_idx,    n_rd_idx;
    logic                   r_out_valid, n_out_valid;
    t_out_item              r_out,       n_out;

    t_cell_ctrl             w_ctrl;
    logic signed [31:0]     w_cell_value [SIS_DEPTH];
    logic                   w_cell_lt    [SIS_DEPTH];
    logic                   w_slot_free;
    logic                   w_accept;
    logic                   w_full;
    logic                   w_rd_last;

    assign w_slot_free = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE) && w_slot_free;
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_full      = (r_count == SIS_CNT_W'(SIS_DEPTH));
    assign w_rd_last   = (SIS_CNT_W'(r_rd_idx) == r_count - SIS_CNT_W'(1));

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // Decode the request and steer the cell chain
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_rd_idx     = r_rd_idx;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out        = r_out;
        w_ctrl.op    = CELL_HOLD;
        w_ctrl.value = i_in_item.value;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    unique case (i_in_item.kind)
                        KIND_INSERT: begin
                            n_out_valid       = 1'b1;
                            n_out.entry_value = '0;
                            n_out.last        = 1'b1;
                            if (w_full) begin
                                n_out.status = ST_DROPPED;
                            end else begin
                                n_out.status = ST_INSERTED;
                                w_ctrl.op    = CELL_INSERT;
                                n_count      = r_count + SIS_CNT_W'(1);
                            end
                        end
                        KIND_READ: begin
                            n_out_valid = 1'b1;
                            if (r_count == '0) begin
                                n_out.status      = ST_EMPTY;
                                n_out.entry_value = '0;
                                n_out.last        = 1'b1;
                            end else begin
                                // emit the head and rotate the chain
                                n_out.status      = ST_EMITTED;
                                n_out.entry_value = w_cell_value[0];
                                n_out.last        = (r_count == SIS_CNT_W'(1));
                                w_ctrl.op         = CELL_ROTATE;
                                if (r_count != SIS_CNT_W'(1)) begin
                                    n_state  = S_READ;
                                    n_rd_idx = SIS_IDX_W'(1);
                                end
                            end
                        end
                        KIND_CLEAR: begin
                            n_out_valid       = 1'b1;
                            n_out.status      = ST_CLEARED;
                            n_out.entry_value = '0;
                            n_out.last        = 1'b1;
                            n_count           = '0;
                        end
                        default: begin
                            // drop unused kind without a result
                        end
                    endcase
                end
            end
            S_READ: begin
                if (w_slot_free) begin
                    n_out_valid       = 1'b1;
                    n_out.status      = ST_EMITTED;
                    n_out.entry_value = w_cell_value[0];
                    n_out.last        = w_rd_last;
                    w_ctrl.op         = CELL_ROTATE;
                    if (w_rd_last) begin
                        n_state  = S_IDLE;
                        n_rd_idx = '0;
                    end else begin
                        n_rd_idx = r_rd_idx + SIS_IDX_W'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_rd_idx    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_rd_idx    <= n_rd_idx;
            r_out_valid <= n_out_valid;
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    // Chain of cells, head at index zero
    for (genvar i = 0; i < SIS_DEPTH; i++) begin : g_cell
        logic               w_prev_lt;
        logic signed [31:0] w_prev_value;
        logic signed [31:0] w_next_value;

        if (i == 0) begin : g_head
            assign w_prev_lt    = 1'b1;
            assign w_prev_value = i_in_item.value;
        end else begin : g_body
            assign w_prev_lt    = w_cell_lt[i-1];
            assign w_prev_value = w_cell_value[i-1];
        end

        if (i == SIS_DEPTH - 1) begin : g_end
            assign w_next_value = w_cell_value[0];
        end else begin : g_mid
            assign w_next_value = w_cell_value[i+1];
        end

        sis_cell u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (w_ctrl),
            .i_occupied   (SIS_CNT_W'(i) < r_count),
            .i_tail       (SIS_CNT_W'(i) == r_count - SIS_CNT_W'(1)),
            .i_prev_lt    (w_prev_lt),
            .i_prev_value (w_prev_value),
            .i_next_value (w_next_value),
            .i_head_value (w_cell_value[0]),
            .o_value      (w_cell_value[i]),
            .o_lt         (w_cell_lt[i])
        );
    end

endmodule

>>> sv/sis_checker.sv
// Port-level checks for the sorted store, bound to its top level.
`include "sorted_insert_store_macros.svh"

module sis_checker
    import sis_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input t_in_item  i_in_item,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_item
);

    // A stalled result stays offered
    `SIS_ASSERT(a_out_hold, o_out_valid && !i_out_ready |=> o_out_valid, "result dropped while stalled")

    // Only emitted entries carry a value
    `SIS_ASSERT(a_value_zero, o_out_valid && o_out_item.status != ST_EMITTED |-> o_out_item.entry_value == '0, "nonzero value on a status result")

    // Every non-entry result ends its request
    `SIS_ASSERT(a_single_last, o_out_valid && o_out_item.status != ST_EMITTED |-> o_out_item.last, "status result without last")

    // Reset empties the output
    `SIS_ASSERT_ALWAYS(a_reset_idle, $past(!i_rst_n) |-> !o_out_valid, "result valid right after reset")

endmodule

bind sorted_insert_store sis_checker u_sis_checker (.*);

>>> bench/tb_sorted_insert_store.sv
// Self-checking testbench for the sorted insert store: shadow-model checks on directed and random traffic.
module tb_sorted_insert_store
    import sis_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    // The unused kind code has no name in the package
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int LIMIT_CYCLES = 400000;
    localparam int PRINT_CAP = 40;

    // Shadow copy of the store plus the queue of results still owed by the block
    class sorted_store_shadow;
        logic signed [31:0] entries [SIS_DEPTH];
        int unsigned        fill;
        t_out_item          owed_results [$];
        int                 errors;

        function new();
            fill = 0;
            errors = 0;
        endfunction

        function void owe(logic [2:0] status, logic signed [31:0] val, logic last);
            t_out_item res;
            res.status = status;
            res.entry_value = val;
            res.last = last;
            owed_results.push_back(res);
        endfunction

        // Apply one accepted request to the shadow store and queue its results
        function void note_request(t_in_item req);
            int unsigned pos;
            int unsigned idx;
            case (req.kind)
                KIND_INSERT: begin
                    if (fill >= SIS_DEPTH) begin
                        owe(ST_DROPPED, '0, 1'b1);
                    end else begin
                        pos = 0;
                        while (pos < fill && entries[pos] < req.value) pos++;
                        for (idx = fill; idx > pos; idx--) entries[idx] = entries[idx - 1];
                        entries[pos] = req.value;
                        fill++;
                        owe(ST_INSERTED, '0, 1'b1);
                    end
                end
                KIND_READ: begin
                    if (fill == 0) begin
                        owe(ST_EMPTY, '0, 1'b1);
                    end else begin
                        for (idx = 0; idx < fill; idx++)
                            owe(ST_EMITTED, entries[idx], (idx + 1 == fill));
                    end
                end
                KIND_CLEAR: begin
                    fill = 0;
                    owe(ST_CLEARED, '0, 1'b1);
                end
                default: begin
                    // unused kind: no result, store untouched
                end
            endcase
        endfunction

        task report_mismatch(string what);
            if (errors < PRINT_CAP) $display("mismatch: %s", what);
            errors++;
        endtask

        // Compare one accepted result with the oldest owed one
        task check_result(t_out_item got);
            t_out_item want;
            if (owed_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result status=%0d value=%0d last=%0b",
                                          got.status, got.entry_value, got.last));
                return;
            end
            want = owed_results.pop_front();
            if (got.status !== want.status)
                report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
            if (got.entry_value !== want.entry_value)
                report_mismatch($sformatf("entry_value %0d, want %0d",
                                          got.entry_value, want.entry_value));
            if (got.last !== want.last)
                report_mismatch($sformatf("last %0b, want %0b", got.last, want.last));
        endtask
    endclass

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_item  i_in_item;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_item o_out_item;

    sorted_store_shadow shadow = new();
    int send_idle_pct;
    int recv_idle_pct;
    int requests_sent;
    int cycle_count;

    sorted_insert_store u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Toggle the result-side ready at random on each falling edge
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            i_out_ready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Check every result taken at a rising edge
    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) shadow.check_result(o_out_item);
        end
    end

    // Abort a run that hangs
    initial begin
        for (cycle_count = 0; cycle_count < LIMIT_CYCLES; cycle_count++) @(posedge i_clk);
        $display("== FAIL ==");
        $finish;
    end

    // Present one request, hold it until accepted; entered and left at a falling edge
    task send_request(input logic [1:0] kind, input logic signed [31:0] val);
        t_in_item req;
        req.kind = kind;
        req.value = val;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_item = req;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        shadow.note_request(req);
        if (kind != KIND_UNUSED) requests_sent++;
        @(negedge i_clk);
    endtask

    // Hold off the sender until every owed result has come back
    task wait_drained();
        i_in_valid = 1'b0;
        while (shadow.owed_results.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Mix of full-range values, small values that repeat, and the extremes
    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2, 3: return $urandom_range(16) - 8;
            default: return $urandom;
        endcase
    endfunction

    // Mostly insert bursts closed by a read, some clears, the rest noise
    task run_phase(input int s_pct, input int r_pct, input int n_requests, input bit pause_mid);
        int goal;
        int burst;
        bit paused;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        goal = requests_sent + n_requests;
        paused = 1'b0;
        while (requests_sent < goal) begin
            if ($urandom_range(99) < 80) begin
                if ($urandom_range(3) == 0) send_request(KIND_CLEAR, $urandom);
                burst = ($urandom_range(4) == 0) ? $urandom_range(12, 20) : $urandom_range(1, 8);
                repeat (burst) send_request(KIND_INSERT, pick_value());
                send_request(KIND_READ, $urandom);
            end else begin
                send_request(2'($urandom_range(3)), $urandom);
            end
            if (pause_mid && !paused && requests_sent >= goal - n_requests / 2) begin
                wait_drained();
                paused = 1'b1;
            end
        end
        wait_drained();
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_item = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        requests_sent = 0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: empty store, extremes, duplicates, unused kind, overflow
        send_request(KIND_READ, 32'h7fff_ffff);
        send_request(KIND_CLEAR, 32'h8000_0000);
        send_request(KIND_INSERT, 32'h7fff_ffff);
        send_request(KIND_INSERT, 32'h8000_0000);
        send_request(KIND_INSERT, 32'h0000_0000);
        send_request(KIND_INSERT, 32'hffff_ffff);
        send_request(KIND_INSERT, 32'h0000_0001);
        send_request(KIND_INSERT, 32'h8000_0000);
        send_request(KIND_INSERT, 32'h7fff_ffff);
        send_request(KIND_INSERT, 32'h5555_5555);
        send_request(KIND_INSERT, 32'haaaa_aaaa);
        send_request(KIND_READ, 32'h0000_0000);
        send_request(KIND_UNUSED, 32'h1234_5678);
        repeat (7) send_request(KIND_INSERT, pick_value());
        send_request(KIND_INSERT, 32'h0000_0000);
        send_request(KIND_READ, 32'hffff_ffff);
        send_request(KIND_CLEAR, 32'h0000_0000);
        send_request(KIND_READ, 32'h0000_0000);
        wait_drained();

        // Random traffic: slow receiver, then slow sender, then full rate
        run_phase(14, 74, 115, 1'b1);
        run_phase(74, 14, 115, 1'b0);
        run_phase(0, 0, 110, 1'b0);

        // Let any stray result show up
        i_in_valid = 1'b0;
        repeat (8) @(negedge i_clk);
        if (shadow.owed_results.size() != 0)
            shadow.report_mismatch($sformatf("%0d results never came",
                                             shadow.owed_results.size()));
        if (shadow.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+sv
sv/sis_pkg.sv
sv/sis_cell.sv
sv/sorted_insert_store.sv
sv/sis_checker.sv
bench/tb_sorted_insert_store.sv
